/* rtl/core/wmdv_pkg.sv */
`timescale 1ns / 1ps
// shared widths, command and status types for the sliding-window mean and variance block
// no dependencies; every other file of the block imports this package

package wmdv_pkg;

  // window length; must be a power of two in 2..256
  localparam int WINDOW   = 16;
  localparam int LOG2_W   = $clog2(WINDOW);
  localparam int PTR_W    = (LOG2_W < 1) ? 1 : LOG2_W;

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + LOG2_W + 1;
  localparam int SQR_W    = 2 * SAMPLE_W - 1;
  localparam int SQ_W     = SQR_W + LOG2_W;
  // 2*sum - WINDOW*mean, and the product of the mean with it
  localparam int T_W      = SUM_W + 2;
  localparam int PROD_W   = SAMPLE_W + T_W;
  localparam int FRAC_W   = 8;
  localparam int VAR_W    = 40;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_MEAN,
    S_PRODUCT,
    S_WRITE
  } wmdv_state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic mean;
    logic product;
    logic write;
  } wmdv_cmd_t;

  typedef struct packed {
    logic out_free;
  } wmdv_status_t;

endpackage

/* rtl/core/wmdv_sample_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying one signed sensor sample per item
// depends on wmdv_pkg

interface wmdv_sample_if;
  import wmdv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* rtl/core/wmdv_result_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying mean, newest deviation and variance per item
// depends on wmdv_pkg

interface wmdv_result_if;
  import wmdv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean;
  logic signed [DIFF_W-1:0]   newest_minus_mean;
  logic [VAR_W-1:0]           variance_q8;

  modport source (output valid, output mean, output newest_minus_mean,
                  output variance_q8, input ready);
  modport sink (input valid, input mean, input newest_minus_mean,
                input variance_q8, output ready);
endinterface

/* rtl/core/wmdv_ctrl.sv */
`timescale 1ns / 1ps
// sequencer: steps each item through square, mean, product and write phases
// depends on wmdv_pkg; drives the datapath through wmdv_cmd_t

module wmdv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wmdv_pkg::wmdv_status_t status,
  output wmdv_pkg::wmdv_cmd_t    cmd
);
  import wmdv_pkg::*;

  wmdv_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean   = 1'b1;
        state_next = S_PRODUCT;
      end
      S_PRODUCT: begin
        cmd.product = 1'b1;
        state_next  = S_WRITE;
      end
      S_WRITE: begin
        // result goes out and the next item may enter in the same cycle
        if (status.out_free) begin
          cmd.write = 1'b1;
          in_ready  = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_SQUARE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE || state == S_WRITE))
    else $error("item taken outside idle or write phase");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> status.out_free)
    else $error("result written over an item not yet taken");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.square)
    else $error("accepted item not followed by square phase");

endmodule

/* rtl/core/wmdv_datapath.sv */
`timescale 1ns / 1ps
// ring store, running sums, squaring and mean-product multipliers, result register
// depends on wmdv_pkg and wmdv_result_if; sequenced by wmdv_ctrl

module wmdv_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  wmdv_pkg::wmdv_cmd_t                 cmd,
  output wmdv_pkg::wmdv_status_t              status,
  input  logic signed [wmdv_pkg::SAMPLE_W-1:0] sample,
  wmdv_result_if.source                       results
);
  import wmdv_pkg::*;

  logic signed [SAMPLE_W-1:0]   ring [WINDOW];
  logic [PTR_W-1:0]             pos;
  logic signed [SUM_W-1:0]      sum;
  logic [SQ_W-1:0]              sq_sum;
  logic                         out_valid;

  logic signed [SAMPLE_W-1:0]   newest;
  logic signed [SAMPLE_W-1:0]   oldest;
  logic [SQR_W-1:0]             sq_new;
  logic [SQR_W-1:0]             sq_old;
  logic signed [SAMPLE_W-1:0]   mean_r;
  logic signed [PROD_W-1:0]     prod;
  logic signed [SAMPLE_W-1:0]   mean_out;
  logic signed [DIFF_W-1:0]     diff_out;
  logic [VAR_W-1:0]             var_out;

  logic signed [2*SAMPLE_W-1:0] p_new;
  logic signed [2*SAMPLE_W-1:0] p_old;
  logic signed [SUM_W-1:0]      sum_adj;
  logic signed [SUM_W-1:0]      mean_full;
  logic signed [T_W-1:0]        t_val;
  logic signed [PROD_W-1:0]     prod_full;
  logic signed [PROD_W-1:0]     dev;
  logic [PROD_W-2:0]            dev_pos;
  logic [PROD_W+FRAC_W-2:0]     var_wide;

  assign p_new = newest * newest;
  assign p_old = oldest * oldest;

  // truncate toward zero: bias negative sums before the arithmetic shift
  assign sum_adj   = sum + (sum[SUM_W-1] ? SUM_W'(WINDOW - 1) : SUM_W'(0));
  assign mean_full = sum_adj >>> LOG2_W;

  // sum (x - m)^2 = sum x^2 - m * (2 sum - WINDOW m)
  assign t_val     = (T_W'(sum) <<< 1) - (T_W'(mean_r) <<< LOG2_W);
  assign prod_full = mean_r * t_val;
  assign dev       = $signed(PROD_W'(sq_sum)) - prod;
  assign dev_pos   = dev[PROD_W-1] ? '0 : dev[PROD_W-2:0];
  assign var_wide  = {dev_pos, {FRAC_W{1'b0}}} >> LOG2_W;

  assign status.out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      pos       <= '0;
      sum       <= '0;
      sq_sum    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ring[pos] <= sample;
        pos       <= (pos == PTR_W'(WINDOW - 1)) ? '0 : pos + PTR_W'(1);
      end
      if (cmd.square) begin
        sum <= sum + SUM_W'(newest) - SUM_W'(oldest);
      end
      if (cmd.mean) begin
        sq_sum <= sq_sum + SQ_W'(sq_new) - SQ_W'(sq_old);
      end
      if (cmd.write) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      newest <= sample;
      oldest <= ring[pos];
    end
    if (cmd.square) begin
      sq_new <= p_new[SQR_W-1:0];
      sq_old <= p_old[SQR_W-1:0];
    end
    if (cmd.mean) begin
      mean_r <= mean_full[SAMPLE_W-1:0];
    end
    if (cmd.product) begin
      prod <= prod_full;
    end
    if (cmd.write) begin
      mean_out <= mean_r;
      diff_out <= DIFF_W'(newest) - DIFF_W'(mean_r);
      var_out  <= var_wide[VAR_W-1:0];
    end
  end

  assign results.valid             = out_valid;
  assign results.mean              = mean_out;
  assign results.newest_minus_mean = diff_out;
  assign results.variance_q8       = var_out;

  a_write_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> results.valid)
    else $error("result register not valid after write");

  a_dev_nonneg: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !dev[PROD_W-1])
    else $error("squared deviation sum went negative");

endmodule

/* rtl/core/window_mean_diff_variance.sv */
`timescale 1ns / 1ps
// top level of the sliding-window mean and variance block
// depends on wmdv_pkg, wmdv_sample_if, wmdv_result_if, wmdv_ctrl, wmdv_datapath
//
//   channel   dir   payload                                    handshake
//   samples   in    sample (s16)                               valid / ready
//   results   out   mean (s16), newest_minus_mean (s17),       valid / ready
//                   variance_q8 (u40, 8 fraction bits)
//
// each item steps through squaring, mean, mean-product multiply and write phases;
// the next item is taken in the write phase, not before the last item is through
// the result register and its valid flag are loaded in the write phase
// reset (rst, synchronous) clears the window store and running sums
// a stalled result holds the write phase; no item is taken until it drains

module window_mean_diff_variance (
  input logic           clk,
  input logic           rst,
  wmdv_sample_if.sink   samples,
  wmdv_result_if.source results
);
  import wmdv_pkg::*;

  wmdv_cmd_t    cmd;
  wmdv_status_t status;

  wmdv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmdv_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .sample  (samples.sample),
    .results (results)
  );

endmodule
